@@ hdl/md5_pkg.sv @@
// md5 engine package: channel types, block job type, round tables and initial chain values
package md5_pkg;

  localparam int MD5_QUEUE_DEPTH = 2;
  localparam int LEN_CNT_W       = 61;
  localparam int ROUND_W         = 6;

  localparam logic [ROUND_W-1:0] LAST_ROUND     = 6'd63;
  localparam logic [5:0]         LAST_LEN_FIT   = 6'd55;
  localparam logic [5:0]         LAST_BYTE_POS  = 6'd63;
  localparam logic [1:0]         WORD_LAST      = 2'd3;
  localparam logic [7:0]         PAD_MARK       = 8'h80;

  localparam logic [3:0][31:0] MD5_IV = {
    32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef struct packed {
    logic [15:0][31:0] words;
    logic              last_blk;
  } blk_job_t;

  function automatic logic [31:0] round_const(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd7;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] lo;
    logic [3:0] g;
    lo = r[3:0];
    case (r[5:4])
      2'd0:    g = lo;
      2'd1:    g = 4'((lo << 2) + lo + 4'd1);
      2'd2:    g = 4'((lo << 1) + lo + 4'd5);
      2'd3:    g = 4'((lo << 3) - lo);
      default: g = lo;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

endpackage

@@ hdl/md5_blk_fifo.sv @@
// md5 block job queue between the byte packer and the round core
module md5_blk_fifo
  import md5_pkg::*;
#(
  parameter int DEPTH = MD5_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  blk_job_t push_data,
  output logic     full,
  input  logic     pop,
  output blk_job_t head,
  output logic     empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  blk_job_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == CNT_FULL);
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("block job pushed into a full queue");
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("block job popped from an empty queue");

endmodule

@@ hdl/md5_front.sv @@
// md5 front end: packs request bytes into blocks, pads at message end, queues block jobs
module md5_front
  import md5_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     q_push,
  output blk_job_t q_data,
  input  logic     q_full
);

  typedef enum logic [1:0] {S_IN, S_PAD, S_LEN} front_state_t;

  front_state_t          state_r;
  logic [15:0][31:0]     buf_r;
  logic [5:0]            pos_r;
  logic [LEN_CNT_W-1:0]  cnt_r;

  logic              accept;
  logic [63:0]       bit_len;
  logic [15:0][31:0] full_words;
  logic [63:0][7:0]  pad_bytes;
  logic [15:0][31:0] pad_words;
  logic [15:0][31:0] len_words;
  logic              len_fits;

  assign in_stall = (state_r != S_IN) || q_full;
  assign accept   = in_valid && !in_stall;
  assign bit_len  = {cnt_r, 3'b000};
  assign len_fits = (pos_r <= LAST_LEN_FIT);

  always_comb begin
    full_words = buf_r;
    full_words[pos_r[5:2]][{pos_r[1:0], 3'b000} +: 8] = in_data.data_byte;
  end

  always_comb begin
    pad_bytes = buf_r;
    for (int i = 0; i < 64; i++) begin
      if (6'(i) == pos_r) begin
        pad_bytes[i] = PAD_MARK;
      end else if (6'(i) > pos_r) begin
        pad_bytes[i] = 8'h00;
      end
    end
    pad_words = pad_bytes;
    if (len_fits) begin
      pad_words[14] = bit_len[31:0];
      pad_words[15] = bit_len[63:32];
    end
    len_words     = '0;
    len_words[14] = bit_len[31:0];
    len_words[15] = bit_len[63:32];
  end

  always_comb begin
    q_push         = 1'b0;
    q_data.words    = pad_words;
    q_data.last_blk = 1'b0;
    case (state_r)
      S_IN: begin
        q_push         = accept && in_data.byte_present && (pos_r == LAST_BYTE_POS);
        q_data.words    = full_words;
        q_data.last_blk = 1'b0;
      end
      S_PAD: begin
        q_push         = !q_full;
        q_data.words    = pad_words;
        q_data.last_blk = len_fits;
      end
      S_LEN: begin
        q_push         = !q_full;
        q_data.words    = len_words;
        q_data.last_blk = 1'b1;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IN;
      pos_r   <= '0;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IN: begin
          if (accept) begin
            if (in_data.byte_present) begin
              buf_r[pos_r[5:2]][{pos_r[1:0], 3'b000} +: 8] <= in_data.data_byte;
              pos_r <= pos_r + 1'b1;
              cnt_r <= cnt_r + 1'b1;
            end
            if (in_data.end_of_message) begin
              state_r <= S_PAD;
            end
          end
        end
        S_PAD: begin
          if (!q_full) begin
            if (len_fits) begin
              pos_r   <= '0;
              cnt_r   <= '0;
              state_r <= S_IN;
            end else begin
              state_r <= S_LEN;
            end
          end
        end
        S_LEN: begin
          if (!q_full) begin
            pos_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_IN;
          end
        end
        default: begin
          state_r <= S_IN;
        end
      endcase
    end
  end

endmodule

@@ hdl/md5_core.sv @@
// md5 round core: 64 rounds per queued block, chain update and digest word output
module md5_core
  import md5_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  blk_job_t  q_head,
  input  logic      q_empty,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FOLD, S_OUT} core_state_t;

  core_state_t       state_r;
  logic [ROUND_W-1:0] round_r;
  logic [3:0][31:0]  chain_r;
  logic [31:0]       a_r;
  logic [31:0]       b_r;
  logic [31:0]       c_r;
  logic [31:0]       d_r;
  logic [1:0]        idx_r;

  logic [31:0] f_val;
  logic [31:0] sum;
  logic [31:0] b_nxt;

  always_comb begin
    case (round_r[5:4])
      2'd0:    f_val = (b_r & c_r) | (~b_r & d_r);
      2'd1:    f_val = (b_r & d_r) | (c_r & ~d_r);
      2'd2:    f_val = b_r ^ c_r ^ d_r;
      2'd3:    f_val = c_r ^ (b_r | ~d_r);
      default: f_val = '0;
    endcase
    sum   = f_val + a_r + round_const(round_r) + q_head.words[msg_index(round_r)];
    b_nxt = b_r + rotl32(sum, rot_amount(round_r));
  end

  assign q_pop                = (state_r == S_FOLD);
  assign out_valid            = (state_r == S_OUT);
  assign out_data.digest_word = chain_r[idx_r];
  assign out_data.word_index  = idx_r;
  assign out_data.last_word   = (idx_r == WORD_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      round_r <= '0;
      chain_r <= MD5_IV;
      idx_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            a_r     <= chain_r[0];
            b_r     <= chain_r[1];
            c_r     <= chain_r[2];
            d_r     <= chain_r[3];
            round_r <= '0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          a_r     <= d_r;
          d_r     <= c_r;
          c_r     <= b_r;
          b_r     <= b_nxt;
          round_r <= round_r + 1'b1;
          if (round_r == LAST_ROUND) begin
            state_r <= S_FOLD;
          end
        end
        S_FOLD: begin
          chain_r[0] <= chain_r[0] + a_r;
          chain_r[1] <= chain_r[1] + b_r;
          chain_r[2] <= chain_r[2] + c_r;
          chain_r[3] <= chain_r[3] + d_r;
          idx_r      <= '0;
          state_r    <= q_head.last_blk ? S_OUT : S_IDLE;
        end
        S_OUT: begin
          if (!out_stall) begin
            if (idx_r == WORD_LAST) begin
              chain_r <= MD5_IV;
              state_r <= S_IDLE;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == S_RUN && round_r == LAST_ROUND) |=> (state_r == S_FOLD && round_r == '0))
    else $error("round counter out of step with the fold");
  assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid && !out_stall && out_data.last_word) |=> (chain_r == MD5_IV && !out_valid))
    else $error("chain not restored after the last digest word");

endmodule

@@ hdl/md5_digest_engine.sv @@
// md5 digest engine top level: byte packer, block job queue and round core
//
//   channel | direction | payload    | handshake
//   in_     | request   | in_item_t  | in_valid / in_stall
//   out_    | result    | out_item_t | out_valid / out_stall
//
// one byte request is taken per cycle while no padding is pushed and the block queue has room
// the round core works on each 64-byte block in steps: load, 64 rounds, fold
// message end adds one or two padding blocks, then 4 digest words
// rst_n is synchronous; it clears the queue, the byte count and restores the chain values
// in_stall rises while padding is pushed or the block queue is full; out_stall holds the word
module md5_digest_engine
  import md5_pkg::*;
#(
  parameter int QUEUE_DEPTH = MD5_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic     q_push;
  blk_job_t q_data;
  logic     q_full;
  logic     q_pop;
  blk_job_t q_head;
  logic     q_empty;

  md5_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_data),
    .q_full   (q_full)
  );

  md5_blk_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  md5_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
